// ===== design/uprm_pkg.sv =====
// ----------------------------------------------------------------------------
// uprm_pkg
// Shared types and constants for the UYVY to planar 4:2:0 converter.
// ----------------------------------------------------------------------------
package uprm_pkg;

  localparam int ADDR_W  = 24;
  localparam int COUNT_W = 13;
  localparam int CFG_W   = 13;
  localparam int INDEX_W = 3;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_PORTRAIT       = 3'd2;
  localparam logic [INDEX_W-1:0] REG_MIRROR         = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LUMA_PITCH     = 3'd4;
  localparam logic [INDEX_W-1:0] REG_CHROMA_A_PITCH = 3'd5;
  localparam logic [INDEX_W-1:0] REG_CHROMA_B_PITCH = 3'd6;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic        portrait;
    logic        mirror;
    logic [12:0] luma_pitch;
    logic [12:0] chroma_a_pitch;
    logic [12:0] chroma_b_pitch;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic        luma_write;
    logic [23:0] luma_addr_first;
    logic [7:0]  luma_first;
    logic [23:0] luma_addr_second;
    logic [7:0]  luma_second;
    logic        chroma_write;
    logic [23:0] chroma_a_addr;
    logic [7:0]  chroma_a;
    logic [23:0] chroma_b_addr;
    logic [7:0]  chroma_b;
    logic        frame_done;
  } out_item_t;

  // classified word handed from the front end to the address pipeline
  typedef struct packed {
    logic [31:0] pixel_word;
    count_t      col;
    count_t      row;
    logic        luma_write;
    logic        chroma_write;
    logic        frame_done;
  } job_t;

endpackage

// ===== design/uprm_front.sv =====
// ----------------------------------------------------------------------------
// uprm_front
// Position tracking and classification of each accepted word.
// ----------------------------------------------------------------------------
module uprm_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  uprm_pkg::cfg_t   cfg,
  input  logic             accept,
  input  uprm_pkg::in_item_t item,
  output uprm_pkg::job_t   job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW:0]   col_step;
  logic [RW:0]   row_step;
  logic          col_wrap;
  logic          row_wrap;
  logic          lw;

  always_comb begin
    col      = item.frame_start ? '0 : column_count;
    row      = item.frame_start ? '0 : row_count;
    col_step = {1'b0, col} + (CW+1)'(2);
    row_step = {1'b0, row} + (RW+1)'(1);
    col_wrap = (col_step >= {{(CW > 11 ? 1 : 12 - CW){1'b0}}, cfg.frame_width} ||
               col_step >= (CW+1)'(MAX_WIDTH));
    row_wrap = (row_step >= {{(RW > 11 ? 1 : 12 - RW){1'b0}}, cfg.frame_height} ||
               row_step >= (RW+1)'(MAX_HEIGHT));
    lw       = cfg.portrait ? (uprm_pkg::count_t'(col) <
                               uprm_pkg::count_t'(cfg.frame_height)) : 1'b1;
    job.pixel_word   = item.pixel_word;
    job.col          = uprm_pkg::count_t'(col);
    job.row          = uprm_pkg::count_t'(row);
    job.luma_write   = lw;
    job.chroma_write = lw && !row[0];
    job.frame_done   = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_step[RW-1:0];
      end else begin
        column_count <= col_step[CW-1:0];
        row_count    <= row;
      end
    end
  end

endmodule

// ===== design/uprm_queue.sv =====
// ----------------------------------------------------------------------------
// uprm_queue
// Two-entry queue between the front end and the address pipeline.
// ----------------------------------------------------------------------------
module uprm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  uprm_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output uprm_pkg::job_t pop_data
);

  uprm_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full      = count[1];
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/uprm_back.sv =====
// ----------------------------------------------------------------------------
// uprm_back
// Address pipeline: products and offsets, then sums into the output register.
// ----------------------------------------------------------------------------
module uprm_back (
  input  logic              clk,
  input  logic              rst,
  input  uprm_pkg::cfg_t    cfg,
  input  logic              job_valid,
  input  uprm_pkg::job_t    job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output uprm_pkg::out_item_t out_data
);

  typedef struct packed {
    uprm_pkg::addr_t prod_luma;
    uprm_pkg::addr_t prod_ca;
    uprm_pkg::addr_t prod_cb;
    uprm_pkg::addr_t off_first;
    uprm_pkg::addr_t off_second;
    uprm_pkg::addr_t off_chroma;
    logic [31:0]     pixel_word;
    logic            luma_write;
    logic            chroma_write;
    logic            frame_done;
  } mid_t;

  mid_t            mid;
  mid_t            mid_next;
  logic            mid_valid;
  logic            out_free;
  logic            mid_load;
  uprm_pkg::addr_t c_a, c_h, r_a, r_h, w_a, half_a, h_a, hh_a, lp_a;
  uprm_pkg::addr_t la1, la2, ca, cb;
  uprm_pkg::out_item_t result;

  assign out_free = !out_valid || out_ready;
  assign mid_load = !mid_valid || out_free;
  assign job_pop  = job_valid && mid_load;

  always_comb begin
    c_a    = uprm_pkg::addr_t'(job.col);
    c_h    = uprm_pkg::addr_t'(job.col >> 1);
    r_a    = uprm_pkg::addr_t'(job.row);
    r_h    = uprm_pkg::addr_t'(job.row >> 1);
    w_a    = uprm_pkg::addr_t'(cfg.frame_width);
    half_a = uprm_pkg::addr_t'(cfg.frame_width >> 1);
    h_a    = uprm_pkg::addr_t'(cfg.frame_height);
    hh_a   = uprm_pkg::addr_t'(cfg.frame_height >> 1);
    lp_a   = uprm_pkg::addr_t'(cfg.luma_pitch);
    mid_next.pixel_word   = job.pixel_word;
    mid_next.luma_write   = job.luma_write;
    mid_next.chroma_write = job.chroma_write;
    mid_next.frame_done   = job.frame_done;
    mid_next.prod_cb      = c_h * uprm_pkg::addr_t'(cfg.chroma_b_pitch);
    if (cfg.portrait) begin
      mid_next.prod_luma  = c_a * lp_a;
      mid_next.prod_ca    = c_h * uprm_pkg::addr_t'(cfg.chroma_a_pitch);
      mid_next.off_first  = h_a - r_a - 24'd1;
      mid_next.off_second = lp_a + h_a - r_a - 24'd1;
      mid_next.off_chroma = hh_a - r_h - 24'd1;
    end else begin
      mid_next.prod_luma  = r_a * w_a;
      mid_next.prod_ca    = r_h * half_a;
      if (cfg.mirror) begin
        mid_next.off_first  = w_a - c_a - 24'd1;
        mid_next.off_second = w_a - c_a - 24'd2;
        mid_next.off_chroma = half_a - c_h - 24'd1;
      end else begin
        mid_next.off_first  = c_a;
        mid_next.off_second = c_a + 24'd1;
        mid_next.off_chroma = c_h;
      end
    end
  end

  always_comb begin
    la1 = mid.prod_luma + mid.off_first;
    la2 = mid.prod_luma + mid.off_second;
    ca  = mid.prod_ca + mid.off_chroma;
    cb  = cfg.portrait ? (mid.prod_cb + mid.off_chroma) : ca;
    result.luma_write       = mid.luma_write;
    result.luma_addr_first  = mid.luma_write ? la1 : '0;
    result.luma_first       = mid.luma_write ? mid.pixel_word[15:8] : '0;
    result.luma_addr_second = mid.luma_write ? la2 : '0;
    result.luma_second      = mid.luma_write ? mid.pixel_word[31:24] : '0;
    result.chroma_write     = mid.chroma_write;
    result.chroma_a_addr    = mid.chroma_write ? ca : '0;
    result.chroma_a         = mid.chroma_write ? mid.pixel_word[23:16] : '0;
    result.chroma_b_addr    = mid.chroma_write ? cb : '0;
    result.chroma_b         = mid.chroma_write ? mid.pixel_word[7:0] : '0;
    result.frame_done       = mid.frame_done;
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      mid <= mid_next;
    end
    if (mid_valid && out_free) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mid_load) begin
        mid_valid <= job_valid;
      end
      if (out_free) begin
        out_valid <= mid_valid;
      end
    end
  end

endmodule

// ===== design/uyvy_to_planar_rotate_mirror.sv =====
// ----------------------------------------------------------------------------
// uyvy_to_planar_rotate_mirror
// Packed UYVY words to planar 4:2:0 write addresses, with portrait and mirror.
// ----------------------------------------------------------------------------
// An accepted word is registered in the queue, then in mid, then in out_data.
// Throughput: one word per cycle while out_ready holds; set by the position
// counters, which advance once per word, and the two-stage address pipeline
// behind a two-entry queue. Reset (synchronous): counters zero, registers to
// their defaults, queue and pipeline empty.
module uyvy_to_planar_rotate_mirror #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  uprm_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output uprm_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [uprm_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [uprm_pkg::CFG_W-1:0]        cfg_data
);

  uprm_pkg::cfg_t cfg;
  uprm_pkg::job_t front_job;
  uprm_pkg::job_t queue_job;
  logic           queue_full;
  logic           queue_valid;
  logic           queue_pop;
  logic           accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= 12'd640;
      cfg.frame_height   <= 12'd480;
      cfg.portrait       <= 1'b0;
      cfg.mirror         <= 1'b0;
      cfg.luma_pitch     <= 13'd480;
      cfg.chroma_a_pitch <= 13'd240;
      cfg.chroma_b_pitch <= 13'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        uprm_pkg::REG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data[11:0];
        uprm_pkg::REG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data[11:0];
        uprm_pkg::REG_PORTRAIT:       cfg.portrait       <= cfg_data[0];
        uprm_pkg::REG_MIRROR:         cfg.mirror         <= cfg_data[0];
        uprm_pkg::REG_LUMA_PITCH:     cfg.luma_pitch     <= cfg_data;
        uprm_pkg::REG_CHROMA_A_PITCH: cfg.chroma_a_pitch <= cfg_data;
        uprm_pkg::REG_CHROMA_B_PITCH: cfg.chroma_b_pitch <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  uprm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_data),
    .job    (front_job)
  );

  uprm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_job),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_valid),
    .pop_data  (queue_job)
  );

  uprm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (queue_valid),
    .job       (queue_job),
    .job_pop   (queue_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/uprm_checker.sv =====
// ----------------------------------------------------------------------------
// uprm_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module uprm_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input uprm_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  a_luma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.luma_write |->
      out_data.luma_addr_first == '0 && out_data.luma_addr_second == '0 &&
      out_data.luma_first == '0 && out_data.luma_second == '0)
    else $error("luma fields set without luma write");

  a_chroma_needs_luma: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.chroma_write |-> out_data.luma_write)
    else $error("chroma write without luma write");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.chroma_write |->
      out_data.chroma_a_addr == '0 && out_data.chroma_b_addr == '0 &&
      out_data.chroma_a == '0 && out_data.chroma_b == '0)
    else $error("chroma fields set without chroma write");

endmodule

bind uyvy_to_planar_rotate_mirror uprm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
